// ===== rtl/stq_pkg.sv =====
// Shared types and codes for the stack-to-dual-queue engine.
`timescale 1ns / 1ps

package stq_pkg;

  // Operation codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_ENQ  = 2'd2;
  localparam logic [1:0] OP_DEQ  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned DATA_W = 32;

  // Input beat
  typedef struct packed {
    logic [1:0]               operation;
    logic                     queue_select;
    logic signed [DATA_W-1:0] push_value;
  } stq_in_t;

  // Result beat
  typedef struct packed {
    logic                     value_valid;
    logic signed [DATA_W-1:0] dequeued_value;
    logic [1:0]               status;
  } stq_out_t;

  // Control status from the sequencer to the output stage
  typedef struct packed {
    logic busy;       // memory read in flight, no new beat taken
    logic res_valid;  // a result is ready to load this cycle
  } stq_stat_t;

endpackage

// ===== rtl/stq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps

module stq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/stq_ctrl.sv =====
// Sequencer: stack and queue pointers, holding register, memory requests.
`timescale 1ns / 1ps

module stq_ctrl #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             acc,
  input  stq_pkg::stq_in_t                 in_data,
  // stack memory
  output logic                             stk_we,
  output logic [$clog2(STACK_DEPTH)-1:0]   stk_waddr,
  output logic [stq_pkg::DATA_W-1:0]       stk_wdata,
  output logic                             stk_re,
  output logic [$clog2(STACK_DEPTH)-1:0]   stk_raddr,
  input  logic [stq_pkg::DATA_W-1:0]       stk_rdata,
  // queue memory, both queues, queue select is the top address bit
  output logic                             q_we,
  output logic [$clog2(QUEUE_DEPTH):0]     q_waddr,
  output logic [stq_pkg::DATA_W-1:0]       q_wdata,
  output logic                             q_re,
  output logic [$clog2(QUEUE_DEPTH):0]     q_raddr,
  input  logic [stq_pkg::DATA_W-1:0]       q_rdata,
  // to output stage
  output stq_pkg::stq_stat_t               stat,
  output stq_pkg::stq_out_t                res
);

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SFW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QFW = $clog2(QUEUE_DEPTH + 1);

  logic [SFW-1:0]             stk_fill_r, stk_fill_nxt;
  logic [SFW-1:0]             stk_top;
  logic [stq_pkg::DATA_W-1:0] held_r, held_nxt;
  logic [QAW-1:0]             q_head_r [2];
  logic [QAW-1:0]             q_head_nxt [2];
  logic [QAW-1:0]             q_tail_r [2];
  logic [QAW-1:0]             q_tail_nxt [2];
  logic [QFW-1:0]             q_fill_r [2];
  logic [QFW-1:0]             q_fill_nxt [2];
  logic                       pend_pop_r, pend_pop_nxt;
  logic                       pend_deq_r, pend_deq_nxt;
  logic                       pend;
  logic                       sel;
  logic                       stk_full, stk_empty, q_full, q_empty;
  logic [1:0]                 status;

  // index advance with wrap at the queue depth
  function automatic logic [QAW-1:0] wrap_inc(input logic [QAW-1:0] idx);
    logic [QAW-1:0] n;
    n = idx + QAW'(1);
    if (idx == QAW'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end
    return n;
  endfunction

  assign sel       = in_data.queue_select;
  assign stk_full  = (stk_fill_r == SFW'(STACK_DEPTH));
  assign stk_empty = (stk_fill_r == '0);
  assign q_full    = (q_fill_r[sel] == QFW'(QUEUE_DEPTH));
  assign q_empty   = (q_fill_r[sel] == '0);
  assign stk_top   = stk_fill_r - SFW'(1);
  assign pend      = pend_pop_r | pend_deq_r;

  // decode the operation into memory requests and a status
  always_comb begin
    stk_we = 1'b0;
    stk_re = 1'b0;
    q_we   = 1'b0;
    q_re   = 1'b0;
    status = stq_pkg::ST_DONE;
    case (in_data.operation)
      stq_pkg::OP_PUSH: begin
        if (stk_full) status = stq_pkg::ST_FULL;
        else stk_we = acc;
      end
      stq_pkg::OP_POP: begin
        if (stk_empty) status = stq_pkg::ST_EMPTY;
        else stk_re = acc;
      end
      stq_pkg::OP_ENQ: begin
        if (q_full) status = stq_pkg::ST_FULL;
        else q_we = acc;
      end
      stq_pkg::OP_DEQ: begin
        if (q_empty) status = stq_pkg::ST_EMPTY;
        else q_re = acc;
      end
      default: begin
        status = stq_pkg::ST_DONE;
      end
    endcase
  end

  // memory addresses and write data
  assign stk_waddr = stk_fill_r[SAW-1:0];
  assign stk_raddr = stk_top[SAW-1:0];
  assign stk_wdata = in_data.push_value;
  assign q_waddr   = {sel, q_tail_r[sel]};
  assign q_raddr   = {sel, q_head_r[sel]};
  assign q_wdata   = held_r;

  // pointer and holding register updates
  always_comb begin
    stk_fill_nxt = stk_fill_r;
    held_nxt     = held_r;
    q_head_nxt   = q_head_r;
    q_tail_nxt   = q_tail_r;
    q_fill_nxt   = q_fill_r;
    pend_pop_nxt = stk_re;
    pend_deq_nxt = q_re;
    if (stk_we) stk_fill_nxt = stk_fill_r + SFW'(1);
    if (stk_re) stk_fill_nxt = stk_top;
    if (pend_pop_r) held_nxt = stk_rdata;
    if (q_we) begin
      q_tail_nxt[sel] = wrap_inc(q_tail_r[sel]);
      q_fill_nxt[sel] = q_fill_r[sel] + QFW'(1);
    end
    if (q_re) begin
      q_head_nxt[sel] = wrap_inc(q_head_r[sel]);
      q_fill_nxt[sel] = q_fill_r[sel] - QFW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stk_fill_r <= '0;
      held_r     <= '0;
      pend_pop_r <= 1'b0;
      pend_deq_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        q_head_r[i] <= '0;
        q_tail_r[i] <= '0;
        q_fill_r[i] <= '0;
      end
    end else begin
      stk_fill_r <= stk_fill_nxt;
      held_r     <= held_nxt;
      pend_pop_r <= pend_pop_nxt;
      pend_deq_r <= pend_deq_nxt;
      for (int i = 0; i < 2; i++) begin
        q_head_r[i] <= q_head_nxt[i];
        q_tail_r[i] <= q_tail_nxt[i];
        q_fill_r[i] <= q_fill_nxt[i];
      end
    end
  end

  // result: immediate for non-reads, in the cycle after the request for memory reads
  always_comb begin
    res.value_valid    = 1'b0;
    res.dequeued_value = '0;
    res.status         = status;
    if (pend) begin
      res.value_valid    = pend_deq_r;
      res.dequeued_value = pend_deq_r ? q_rdata : '0;
      res.status         = stq_pkg::ST_DONE;
    end
  end

  assign stat.busy      = pend;
  assign stat.res_valid = pend | (acc & ~stk_re & ~q_re);

  // no beat is taken while a read is in flight
  a_no_acc_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend |-> !acc) else $error("beat accepted during pending read");

  // a read request always leads to its result the next cycle
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (stk_re || q_re) |=> (pend && stat.res_valid))
    else $error("read result not produced");

  // fill counters stay within bounds
  a_stk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_fill_r <= SFW'(STACK_DEPTH)) else $error("stack fill overflow");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_fill_r[0] <= QFW'(QUEUE_DEPTH)) && (q_fill_r[1] <= QFW'(QUEUE_DEPTH)))
    else $error("queue fill overflow");

endmodule

// ===== rtl/stack_to_dual_queue_engine.sv =====
// Top level: stack and queue memories, sequencer and result register.
//
//   channel  direction  handshake         payload
//   in_      input      in_valid/in_stall     stq_in_t  (operation, queue_select, push_value)
//   out_     output     out_valid/out_stall   stq_out_t (value_valid, dequeued_value, status)
//
// Push, enqueue and any rejected operation produce their result in the cycle they
// are taken: a new beat can be taken every cycle while the result register drains.
// A successful pop or dequeue reads the stack or queue memory, whose read port is
// registered; input is stalled for that read.
// Reset clears all pointers, fill counts and the holding register; the memories
// are not cleared. A stalled result holds in the output register; apart from
// the read cycle, input stalls only when that register cannot be emptied.
`timescale 1ns / 1ps

module stack_to_dual_queue_engine #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stq_pkg::stq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output stq_pkg::stq_out_t out_data
);

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);

  logic                       acc;
  stq_pkg::stq_stat_t         stat;
  stq_pkg::stq_out_t          res;
  logic                       stk_we, stk_re, q_we, q_re;
  logic [SAW-1:0]             stk_waddr, stk_raddr;
  logic [QAW:0]               q_waddr, q_raddr;
  logic [stq_pkg::DATA_W-1:0] stk_wdata, stk_rdata, q_wdata, q_rdata;
  logic                       out_valid_r, out_valid_nxt;
  stq_pkg::stq_out_t          out_data_r, out_data_nxt;

  // input handshake
  assign in_stall = stat.busy | (out_valid_r & out_stall);
  assign acc      = in_valid & ~in_stall;

  stq_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_data   (in_data),
    .stk_we    (stk_we),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_re    (stk_re),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata),
    .q_we      (q_we),
    .q_waddr   (q_waddr),
    .q_wdata   (q_wdata),
    .q_re      (q_re),
    .q_raddr   (q_raddr),
    .q_rdata   (q_rdata),
    .stat      (stat),
    .res       (res)
  );

  // stack memory
  stq_ram #(
    .WIDTH (stq_pkg::DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stk_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_en   (stk_re),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  // both queues share one memory, queue select on the top address bit;
  // each queue owns a power-of-two half so the select bit never overruns
  stq_ram #(
    .WIDTH (stq_pkg::DATA_W),
    .DEPTH (2 ** (QAW + 1))
  ) u_q_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_waddr),
    .wr_data (q_wdata),
    .rd_en   (q_re),
    .rd_addr (q_raddr),
    .rd_data (q_rdata)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (stat.res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result never lands on a beat still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.res_valid |-> !(out_valid_r && out_stall))
    else $error("result register overwritten");

  // output register is empty while a read is in flight
  a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !out_valid_r) else $error("output held during read");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the stack-to-dual-queue engine.
`timescale 1ns / 1ps

module tb_top;

  localparam int STACK_DEPTH = 256;
  localparam int QUEUE_DEPTH = 256;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  stq_pkg::stq_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  stq_pkg::stq_out_t out_data;

  // Traffic shaping knobs, idle and stall shares in percent
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  logic hold_on    = 1'b0;
  int   mismatches = 0;

  // Results still owed by the engine, oldest first
  stq_pkg::stq_out_t pending_results[$];

  // Shadow copy of the engine state
  logic signed [stq_pkg::DATA_W-1:0] stk_mem [STACK_DEPTH];
  int                                stk_cnt = 0;
  logic signed [stq_pkg::DATA_W-1:0] held_val = '0;
  logic signed [stq_pkg::DATA_W-1:0] fifo_mem [2][QUEUE_DEPTH];
  int                                fifo_head [2] = '{0, 0};
  int                                fifo_tail [2] = '{0, 0};
  int                                fifo_cnt  [2] = '{0, 0};

  stack_to_dual_queue_engine #(
    .STACK_DEPTH(STACK_DEPTH),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one operation to the shadow state and return the result it owes
  function automatic stq_pkg::stq_out_t apply_op(input stq_pkg::stq_in_t b);
    stq_pkg::stq_out_t r;
    int                s;
    r = '0;
    r.status = stq_pkg::ST_DONE;
    s = b.queue_select;
    case (b.operation)
      stq_pkg::OP_PUSH: begin
        if (stk_cnt >= STACK_DEPTH) begin
          r.status = stq_pkg::ST_FULL;
        end else begin
          stk_mem[stk_cnt] = b.push_value;
          stk_cnt++;
        end
      end
      stq_pkg::OP_POP: begin
        if (stk_cnt == 0) begin
          r.status = stq_pkg::ST_EMPTY;
        end else begin
          stk_cnt--;
          held_val = stk_mem[stk_cnt];
        end
      end
      stq_pkg::OP_ENQ: begin
        if (fifo_cnt[s] >= QUEUE_DEPTH) begin
          r.status = stq_pkg::ST_FULL;
        end else begin
          fifo_mem[s][fifo_tail[s]] = held_val;
          fifo_tail[s] = (fifo_tail[s] + 1) % QUEUE_DEPTH;
          fifo_cnt[s]++;
        end
      end
      default: begin
        if (fifo_cnt[s] == 0) begin
          r.status = stq_pkg::ST_EMPTY;
        end else begin
          r.value_valid    = 1'b1;
          r.dequeued_value = fifo_mem[s][fifo_head[s]];
          fifo_head[s] = (fifo_head[s] + 1) % QUEUE_DEPTH;
          fifo_cnt[s]--;
        end
      end
    endcase
    return r;
  endfunction

  function automatic stq_pkg::stq_in_t beat_of(input logic [1:0] op, input logic sel,
                                               input logic [31:0] val);
    stq_pkg::stq_in_t b;
    b.operation    = op;
    b.queue_select = sel;
    b.push_value   = val;
    return b;
  endfunction

  // Random operation; push share in percent, the rest split over pop/enq/deq
  function automatic stq_pkg::stq_in_t random_beat(input int push_w);
    int         pick;
    logic [1:0] op;
    pick = $urandom_range(99);
    if (pick < push_w) begin
      op = stq_pkg::OP_PUSH;
    end else if (pick < push_w + 25) begin
      op = stq_pkg::OP_POP;
    end else if (pick < push_w + 50) begin
      op = stq_pkg::OP_ENQ;
    end else begin
      op = stq_pkg::OP_DEQ;
    end
    return beat_of(op, 1'($urandom_range(1)), $urandom);
  endfunction

  // Result side: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin : check_result
    stq_pkg::stq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: %p", out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.value_valid !== want.value_valid) begin
          $error("value_valid: expected %0d, got %0d", want.value_valid,
                 out_data.value_valid);
          mismatches++;
        end
        if (out_data.dequeued_value !== want.dequeued_value) begin
          $error("dequeued_value: expected %0d, got %0d", want.dequeued_value,
                 out_data.dequeued_value);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
      end
    end
  end

  // Offer one beat, with a random idle gap first; returns on the accepting edge.
  // in_valid stays high so a following beat goes out back to back.
  task automatic send_beat(input stq_pkg::stq_in_t beat);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(apply_op(beat));
  endtask

  // Drop valid and let every owed result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Empty stores, field extremes and every operation on both queues
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_beat(beat_of(stq_pkg::OP_POP,  1'b0, $urandom));    // pop on empty stack
    send_beat(beat_of(stq_pkg::OP_DEQ,  1'b0, $urandom));    // dequeue empty A
    send_beat(beat_of(stq_pkg::OP_DEQ,  1'b1, $urandom));    // dequeue empty B
    send_beat(beat_of(stq_pkg::OP_ENQ,  1'b0, $urandom));    // holding reg still zero
    send_beat(beat_of(stq_pkg::OP_DEQ,  1'b0, $urandom));
    send_beat(beat_of(stq_pkg::OP_PUSH, 1'b1, 32'h7FFF_FFFF));
    send_beat(beat_of(stq_pkg::OP_PUSH, 1'b0, 32'h8000_0000));
    send_beat(beat_of(stq_pkg::OP_PUSH, 1'b1, 32'hFFFF_FFFF));
    send_beat(beat_of(stq_pkg::OP_PUSH, 1'b0, 32'h0000_0000));
    send_beat(beat_of(stq_pkg::OP_POP,  1'b1, $urandom));
    send_beat(beat_of(stq_pkg::OP_POP,  1'b0, $urandom));
    send_beat(beat_of(stq_pkg::OP_ENQ,  1'b1, $urandom));
    send_beat(beat_of(stq_pkg::OP_POP,  1'b1, $urandom));
    send_beat(beat_of(stq_pkg::OP_ENQ,  1'b0, $urandom));
    send_beat(beat_of(stq_pkg::OP_POP,  1'b0, $urandom));
    send_beat(beat_of(stq_pkg::OP_ENQ,  1'b1, $urandom));
    send_beat(beat_of(stq_pkg::OP_ENQ,  1'b0, $urandom));
    send_beat(beat_of(stq_pkg::OP_DEQ,  1'b1, $urandom));
    send_beat(beat_of(stq_pkg::OP_DEQ,  1'b1, $urandom));
    send_beat(beat_of(stq_pkg::OP_DEQ,  1'b0, $urandom));
    send_beat(beat_of(stq_pkg::OP_DEQ,  1'b0, $urandom));
    send_beat(beat_of(stq_pkg::OP_DEQ,  1'b1, $urandom));
    send_beat(beat_of(stq_pkg::OP_POP,  1'b0, $urandom));    // stack empty again
    send_beat(beat_of(stq_pkg::OP_ENQ,  1'b1, $urandom));    // reuses last popped value
    send_beat(beat_of(stq_pkg::OP_DEQ,  1'b1, $urandom));
    wait_drained();
  endtask

  // Fill the stack past full, push it through one queue past full, pop the stack
  // past empty, then drain the queue past empty; queue pointers wrap on the way
  task automatic test_fill_limits(input logic sel, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    while (stk_cnt < STACK_DEPTH) send_beat(beat_of(stq_pkg::OP_PUSH, sel, $urandom));
    send_beat(beat_of(stq_pkg::OP_PUSH, sel, $urandom));
    while (fifo_cnt[sel] < QUEUE_DEPTH) begin
      if (stk_cnt == 0) send_beat(beat_of(stq_pkg::OP_PUSH, sel, $urandom));
      send_beat(beat_of(stq_pkg::OP_POP, sel, $urandom));
      send_beat(beat_of(stq_pkg::OP_ENQ, sel, $urandom));
    end
    send_beat(beat_of(stq_pkg::OP_ENQ, sel, $urandom));
    while (stk_cnt > 0) send_beat(beat_of(stq_pkg::OP_POP, sel, $urandom));
    send_beat(beat_of(stq_pkg::OP_POP, sel, $urandom));
    while (fifo_cnt[sel] > 0) send_beat(beat_of(stq_pkg::OP_DEQ, sel, $urandom));
    send_beat(beat_of(stq_pkg::OP_DEQ, sel, $urandom));
    wait_drained();
  endtask

  // Random operation mix under one traffic setting
  task automatic test_random(input int n, input int idle, input int stall,
                             input int push_w);
    int i;
    idle_pct  = idle;
    stall_pct = stall;
    for (i = 0; i < n; i++) send_beat(random_beat(push_w));
    wait_drained();
  endtask

  // Result side held off for a long stretch while beats keep coming
  task automatic test_backpressure();
    int i;
    idle_pct  = 0;
    stall_pct = 0;
    fork
      begin
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
      end
      begin
        for (i = 0; i < 60; i++) send_beat(random_beat(30));
      end
    join
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_limits(1'b0, 0, 0);
    test_random(200, 0, 0, 30);
    test_random(150, 87, 0, 35);
    test_random(150, 0, 87, 25);
    test_random(150, 6, 6, 30);
    test_backpressure();
    test_random(100, 0, 0, 40);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/stq_pkg.sv
rtl/stq_ram.sv
rtl/stq_ctrl.sv
rtl/stack_to_dual_queue_engine.sv
sim/tb_top.sv
